// ===== src/imsr_pkg.sv =====
`timescale 1ns / 1ps

package imsr_pkg;

   // Field widths.
   localparam int PERIOD_W = 24;
   localparam int DUTY_W   = 16;
   localparam int SPEED_W  = 30;
   localparam int ERR_W    = 31;
   localparam int RPS_W    = 25;
   localparam int TGT_W    = 6;

   // Serial divider sizing: one quotient bit per cycle.
   localparam int QUO_W    = SPEED_W;
   localparam int CNT_W    = $clog2(QUO_W + 1);
   localparam logic [QUO_W-1:0] SPEED_NUM = QUO_W'(800000000);

   // Divide-by-40 lane that runs beside the divider.
   localparam int TARGET_SCALE = 40;
   localparam int R40_W        = 6;
   localparam int TGT40_W      = 11;

   // Integrator sum, wide enough for the exact sum.
   localparam int SUM_W = 32;

   // Target adjustment.
   localparam int TARGET_MAX   = 50;
   localparam int TARGET_STEP  = 5;
   localparam int TARGET_RESET = 40;

   // Register reset values.
   localparam logic [DUTY_W-1:0] DUTY_MIN_RESET = DUTY_W'(100);
   localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = DUTY_W'(39900);

   // Register map.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MAX = 1'b1;

   // Divider status seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== src/imsr_req_if.sv =====
`timescale 1ns / 1ps

interface imsr_req_if import imsr_pkg::*;;
   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] period;
   logic                raise;
   logic                lower;

   modport source (output valid, output period, output raise, output lower, input ready);
   modport sink   (input valid, input period, input raise, input lower, output ready);
endinterface

// ===== src/imsr_rsp_if.sv =====
`timescale 1ns / 1ps

interface imsr_rsp_if import imsr_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [DUTY_W-1:0]       duty;
   logic [SPEED_W-1:0]      speed;
   logic signed [ERR_W-1:0] speed_error;
   logic [RPS_W-1:0]        measured_rps;
   logic [TGT_W-1:0]        target_rps;

   modport source (output valid, output duty, output speed, output speed_error,
                   output measured_rps, output target_rps, input ready);
   modport sink   (input valid, input duty, input speed, input speed_error,
                   input measured_rps, input target_rps, output ready);
endinterface

// ===== src/imsr_div.sv =====
`timescale 1ns / 1ps

module imsr_div import imsr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PERIOD_W-1:0] divisor,
   output div_status_type      status,
   output logic [QUO_W-1:0]    quotient,
   output logic [RPS_W-1:0]    rps
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [QUO_W-1:0]    num_ff, num_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [R40_W-1:0]    r40_ff, r40_in;
   logic [RPS_W-1:0]    rps_ff, rps_in;

   logic [PERIOD_W:0]   trial;
   logic                qbit;
   logic [R40_W:0]      trial40;
   logic                qbit40;

   // One restoring step: bring down the next numerator bit and try the divisor.
   assign trial   = {rem_ff, num_ff[QUO_W-1]};
   assign qbit    = (trial >= {1'b0, dvs_ff});
   // The quotient bits come out MSB first, so they feed a divide-by-40 step too.
   assign trial40 = {r40_ff, qbit};
   assign qbit40  = (trial40 >= (R40_W+1)'(TARGET_SCALE));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      r40_in  = r40_ff;
      rps_in  = rps_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = SPEED_NUM;
         rem_in  = '0;
         dvs_in  = divisor;
         r40_in  = '0;
         rps_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[QUO_W-2:0], qbit};
         rem_in = qbit ? PERIOD_W'(trial - {1'b0, dvs_ff}) : trial[PERIOD_W-1:0];
         r40_in = qbit40 ? R40_W'(trial40 - (R40_W+1)'(TARGET_SCALE))
                         : trial40[R40_W-1:0];
         rps_in = {rps_ff[RPS_W-2:0], qbit40};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      r40_ff <= r40_in;
      rps_ff <= rps_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = num_ff;
   assign rps         = rps_ff;

   // A new division is only started on an idle unit.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   // The step counter stays inside the quotient length.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff < CNT_W'(QUO_W)))
      else $error("divider step count out of range");

   // The done pulse comes only once the unit has gone idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

// ===== src/integral_motor_speed_regulator.sv =====
`timescale 1ns / 1ps

// Integral motor speed regulator.
// req_bus carries one beat per tachometer reading: the rotation period in bus
// cycles and the raise and lower button flags. rsp_bus returns one beat per
// request with the new duty, the measured speed in 0.025 rps units, the speed
// error, the speed in whole rps and the target speed.
// The csr_ port writes the duty clamps (index 0 lower, index 1 upper); the
// user is to write them only while the block is idle, which the block itself
// does not enforce. A write takes effect at the clock edge. The speed comes
// from a bit-serial divider that yields one quotient bit per cycle; the speed
// in rps is formed by a divide-by-40 step on the same quotient bits. The
// ST_ERR, ST_SUM, ST_LO and ST_HI states then pick up the quotient and form
// the error, the integrator sum and the two clamps. A new request is taken
// only in the idle state, once the previous response is in the output register.
// Reset sets the target to 40 rps, the integrator to zero and the clamps to
// 100 and 39900. A stalled receiver holds the response in the output
// register; the next request is still taken and processed, and its result
// waits in the last stage until the output register is free.
module integral_motor_speed_regulator import imsr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   imsr_req_if.sink             req_bus,
   imsr_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DUTY_W-1:0]    csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_ERR  = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_LO   = 3'd4;
   localparam logic [2:0] ST_HI   = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [TGT_W-1:0]        target_ff, target_in;
   logic [DUTY_W-1:0]       accum_ff, accum_in;
   logic [DUTY_W-1:0]       duty_min_ff, duty_max_ff;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]       rsp_duty_ff;
   logic [SPEED_W-1:0]      rsp_speed_ff;
   logic signed [ERR_W-1:0] rsp_err_ff;
   logic [RPS_W-1:0]        rsp_rps_ff;
   logic [TGT_W-1:0]        rsp_target_ff;

   logic                    req_beat;
   logic                    out_free;
   logic                    out_load;
   logic [PERIOD_W-1:0]     divisor;
   logic [TGT_W:0]          target_up;
   logic [TGT40_W-1:0]      target40;
   logic                    round_up;
   div_status_type          div_status;
   logic [QUO_W-1:0]        div_quotient;
   logic [RPS_W-1:0]        div_rps;

   assign req_beat = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign out_load = (state_ff == ST_HI) && out_free;

   // A zero period counts as one bus cycle.
   assign divisor = (req_bus.period == '0) ? PERIOD_W'(1) : req_bus.period;

   imsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_beat),
      .divisor  (divisor),
      .status   (div_status),
      .quotient (div_quotient),
      .rps      (div_rps)
   );

   // Button handling: a lone flag moves the target by one step within range.
   assign target_up = {1'b0, target_ff} + (TGT_W+1)'(TARGET_STEP);

   always_comb begin
      target_in = target_ff;
      if (req_beat) begin
         if (req_bus.raise && !req_bus.lower) begin
            if (target_up <= (TGT_W+1)'(TARGET_MAX)) begin
               target_in = target_up[TGT_W-1:0];
            end
         end else if (req_bus.lower && !req_bus.raise) begin
            if (target_ff >= TGT_W'(TARGET_STEP)) begin
               target_in = target_ff - TGT_W'(TARGET_STEP);
            end
         end
      end
   end

   // Error and integrator datapath.
   assign target40 = TGT40_W'(target_ff) * TGT40_W'(TARGET_SCALE);
   // Truncation toward zero: floor of err/4, plus one for a negative value
   // with a nonzero remainder.
   assign round_up = err_ff[ERR_W-1] && (err_ff[1:0] != 2'b00);

   always_comb begin
      err_in = $signed({{(ERR_W-TGT40_W){1'b0}}, target40}) - $signed({1'b0, div_quotient});
      sum_in = sum_ff;
      unique case (state_ff)
         ST_SUM: begin
            sum_in = $signed({{(SUM_W-DUTY_W){1'b0}}, accum_ff})
                   + $signed({{(SUM_W-ERR_W+2){err_ff[ERR_W-1]}}, err_ff[ERR_W-1:2]})
                   + $signed({{(SUM_W-1){1'b0}}, round_up});
         end
         ST_LO: begin
            if (sum_ff < $signed({{(SUM_W-DUTY_W){1'b0}}, duty_min_ff})) begin
               sum_in = $signed({{(SUM_W-DUTY_W){1'b0}}, duty_min_ff});
            end
         end
         ST_IDLE, ST_DIV, ST_ERR, ST_HI: begin
            sum_in = sum_ff;
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase
   end

   // Upper clamp feeds both the integrator and the response.
   always_comb begin
      accum_in = accum_ff;
      if (out_load) begin
         if (sum_ff > $signed({{(SUM_W-DUTY_W){1'b0}}, duty_max_ff})) begin
            accum_in = duty_max_ff;
         end else begin
            accum_in = sum_ff[DUTY_W-1:0];
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_beat) state_in = ST_DIV;
         ST_DIV:  if (div_status.done) state_in = ST_ERR;
         ST_ERR:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_LO;
         ST_LO:   state_in = ST_HI;
         ST_HI:   if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= TGT_W'(TARGET_RESET);
         accum_ff     <= '0;
         duty_min_ff  <= DUTY_MIN_RESET;
         duty_max_ff  <= DUTY_MAX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         accum_ff     <= accum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DUTY_MIN: duty_min_ff <= csr_wdata;
               CSR_DUTY_MAX: duty_max_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_ERR) begin
         err_ff <= err_in;
      end
      sum_ff <= sum_in;
      if (out_load) begin
         rsp_duty_ff   <= accum_in;
         rsp_speed_ff  <= div_quotient;
         rsp_err_ff    <= err_ff;
         rsp_rps_ff    <= div_rps;
         rsp_target_ff <= target_ff;
      end
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.duty         = rsp_duty_ff;
   assign rsp_bus.speed        = rsp_speed_ff;
   assign rsp_bus.speed_error  = rsp_err_ff;
   assign rsp_bus.measured_rps = rsp_rps_ff;
   assign rsp_bus.target_rps   = rsp_target_ff;

   // A taken request always starts a division.
   a_beat_starts_div: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_DIV) && div_status.busy)
      else $error("request beat did not start the divider");

   // The divider only finishes while the sequencer waits for it.
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // The delivered duty never exceeds the upper clamp in force at the load.
   a_duty_clamped: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_duty_ff <= $past(duty_max_ff)))
      else $error("duty above upper clamp");

   // The target stays within its range.
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      target_ff <= TGT_W'(TARGET_MAX))
      else $error("target speed out of range");

endmodule

// ===== dv/tb_integral_motor_speed_regulator.sv =====
`timescale 1ns / 1ps

module tb_integral_motor_speed_regulator;
   import imsr_pkg::*;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 85;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

   // Handshake pressure modes.
   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mode_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic                raise;
      logic                lower;
   } reading_type;

   typedef struct packed {
      logic [DUTY_W-1:0]       duty;
      logic [SPEED_W-1:0]      speed;
      logic signed [ERR_W-1:0] speed_error;
      logic [RPS_W-1:0]        measured_rps;
      logic [TGT_W-1:0]        target_rps;
   } regulator_out_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DUTY_W-1:0]    csr_wdata;

   imsr_req_if req_bus ();
   imsr_rsp_if rsp_bus ();

   integral_motor_speed_regulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Readings waiting to be sent and regulator outputs waiting to arrive.
   reading_type       reading_q[$];
   regulator_out_type duty_update_q[$];
   int                readings_queued = 0;
   int                readings_taken  = 0;
   int                fail_count      = 0;
   int                quiet_cycles    = 0;
   flow_mode_type     flow_mode       = FLOW_FREE;
   logic              req_fire;

   // Shadow copy of the regulator state and clamps.
   logic [DUTY_W-1:0] duty_shadow;
   logic [TGT_W-1:0]  target_shadow;
   logic [DUTY_W-1:0] clamp_lo;
   logic [DUTY_W-1:0] clamp_hi;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic bit chance(int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   // Applies one reading to the shadow state and returns the new outputs.
   function automatic regulator_out_type regulate(reading_type r);
      regulator_out_type res;
      longint unsigned   divisor;
      longint unsigned   spd;
      longint unsigned   rps;
      longint            err;
      longint            sum;
      logic [63:0]       err_bits;
      if (r.raise && !r.lower) begin
         if (int'(target_shadow) + TARGET_STEP <= TARGET_MAX)
            target_shadow = target_shadow + TGT_W'(TARGET_STEP);
      end else if (r.lower && !r.raise) begin
         if (int'(target_shadow) >= TARGET_STEP)
            target_shadow = target_shadow - TGT_W'(TARGET_STEP);
      end
      divisor = (r.period == '0) ? 64'd1 : 64'(r.period);
      spd = 64'(SPEED_NUM) / divisor;
      rps = spd / TARGET_SCALE;
      err = longint'(target_shadow) * TARGET_SCALE - longint'(spd);
      // Signed division truncates toward zero, as the integrator needs.
      sum = longint'(duty_shadow) + err / 4;
      if (sum < longint'(clamp_lo))
         sum = longint'(clamp_lo);
      if (sum > longint'(clamp_hi))
         sum = longint'(clamp_hi);
      duty_shadow = sum[DUTY_W-1:0];
      err_bits = err;
      res.duty         = duty_shadow;
      res.speed        = spd[SPEED_W-1:0];
      res.speed_error  = err_bits[ERR_W-1:0];
      res.measured_rps = rps[RPS_W-1:0];
      res.target_rps   = target_shadow;
      return res;
   endfunction

   function automatic reading_type make_reading(logic [PERIOD_W-1:0] p, logic up, logic dn);
      reading_type r;
      r.period = p;
      r.raise  = up;
      r.lower  = dn;
      return r;
   endfunction

   // Mostly periods near the regulation range, with full-range and corner noise.
   function automatic reading_type random_reading();
      reading_type r;
      int          sel;
      int          btn;
      sel = $urandom_range(99, 0);
      if (sel < 55)
         r.period = PERIOD_W'($urandom_range(32'(PERIOD_MAX), 320000));
      else if (sel < 80)
         r.period = PERIOD_W'($urandom());
      else if (sel < 90)
         r.period = PERIOD_W'($urandom_range(4095, 0));
      else begin
         case ($urandom_range(3, 0))
            0:       r.period = '0;
            1:       r.period = PERIOD_W'(1);
            2:       r.period = PERIOD_W'(2);
            default: r.period = PERIOD_MAX;
         endcase
      end
      btn = $urandom_range(99, 0);
      r.raise = (btn < 25) || (btn >= 50 && btn < 62);
      r.lower = (btn >= 25 && btn < 62);
      return r;
   endfunction

   task automatic queue_reading(reading_type r);
      reading_q.push_back(r);
      readings_queued++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DUTY_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Returns at a falling edge once every reading has come back and the block has settled.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (readings_taken != readings_queued || duty_update_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: holds a beat until it is taken, and may idle between beats.
   always @(negedge clock) begin : req_driver
      reading_type r;
      int          idle_pct;
      int          stall_pct;
      idle_pct  = (flow_mode == FLOW_SENDER_IDLE) ? 84 : (flow_mode == FLOW_BOTH) ? 13 : 0;
      stall_pct = (flow_mode == FLOW_RECEIVER_STALL) ? 84 : (flow_mode == FLOW_BOTH) ? 13 : 0;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_fire) begin
            if (reading_q.size() != 0 && !chance(idle_pct)) begin
               r = reading_q.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.period <= r.period;
               req_bus.raise  <= r.raise;
               req_bus.lower  <= r.lower;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= !chance(stall_pct);
      end
   end

   // Monitor: tracks register writes, predicts on each request beat and
   // checks each response beat against the oldest prediction.
   always @(posedge clock) begin : beat_monitor
      regulator_out_type want;
      reading_type       r;
      logic              any_fire;
      if (reset) begin
         duty_shadow   = '0;
         target_shadow = TGT_W'(TARGET_RESET);
         clamp_lo      = DUTY_MIN_RESET;
         clamp_hi      = DUTY_MAX_RESET;
         duty_update_q.delete();
         quiet_cycles  = 0;
         req_fire     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DUTY_MIN: clamp_lo = csr_wdata;
               CSR_DUTY_MAX: clamp_hi = csr_wdata;
               default: ;
            endcase
         end
         any_fire = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            any_fire = 1'b1;
            if (duty_update_q.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count++;
            end else begin
               want = duty_update_q.pop_front();
               if (rsp_bus.duty !== want.duty) begin
                  $error("duty: expected %0d, actual %0d", want.duty, rsp_bus.duty);
                  fail_count++;
               end
               if (rsp_bus.speed !== want.speed) begin
                  $error("speed: expected %0d, actual %0d", want.speed, rsp_bus.speed);
                  fail_count++;
               end
               if (rsp_bus.speed_error !== want.speed_error) begin
                  $error("speed_error: expected %0d, actual %0d",
                         want.speed_error, rsp_bus.speed_error);
                  fail_count++;
               end
               if (rsp_bus.measured_rps !== want.measured_rps) begin
                  $error("measured_rps: expected %0d, actual %0d",
                         want.measured_rps, rsp_bus.measured_rps);
                  fail_count++;
               end
               if (rsp_bus.target_rps !== want.target_rps) begin
                  $error("target_rps: expected %0d, actual %0d",
                         want.target_rps, rsp_bus.target_rps);
                  fail_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            any_fire = 1'b1;
            r.period = req_bus.period;
            r.raise  = req_bus.raise;
            r.lower  = req_bus.lower;
            duty_update_q.push_back(regulate(r));
            readings_taken++;
         end
         req_fire <= req_bus.valid && req_bus.ready;
         // Watchdog on cycles without any beat.
         if (any_fire)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Stimulus sequence.
   initial begin : stimulus
      logic [DUTY_W-1:0] lo;
      logic [DUTY_W-1:0] hi;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_DUTY_MIN;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.period = '0;
      req_bus.raise  = 1'b0;
      req_bus.lower  = 1'b0;
      rsp_bus.ready  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero and tiny periods, the longest period, target limits.
      queue_reading(make_reading('0, 1'b0, 1'b0));
      queue_reading(make_reading(PERIOD_W'(1), 1'b0, 1'b0));
      queue_reading(make_reading(PERIOD_W'(2), 1'b1, 1'b1));
      queue_reading(make_reading(PERIOD_MAX, 1'b1, 1'b0));
      queue_reading(make_reading(PERIOD_MAX, 1'b1, 1'b0));
      queue_reading(make_reading(PERIOD_MAX, 1'b1, 1'b0));
      queue_reading(make_reading(PERIOD_MAX, 1'b1, 1'b1));
      queue_reading(make_reading(PERIOD_W'(400000), 1'b0, 1'b0));
      // Walk the target down past zero so the last lower press is ignored.
      for (int i = 0; i < 11; i++)
         queue_reading(make_reading((i % 2) ? PERIOD_W'(24'h800000) : PERIOD_MAX, 1'b0, 1'b1));
      queue_reading(make_reading(PERIOD_W'(24'hAAAAAA), 1'b1, 1'b0));
      queue_reading(make_reading(PERIOD_W'(24'h555555), 1'b0, 1'b0));
      queue_reading(make_reading(PERIOD_MAX, 1'b0, 1'b1));
      wait_drained();

      // Random phases, each with its own clamp setting and handshake pressure.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin lo = '0;               hi = '1;               end
            1: begin lo = DUTY_MIN_RESET;   hi = DUTY_MAX_RESET;   end
            2: begin lo = DUTY_W'(30000);   hi = DUTY_W'(2000);    end
            3: begin lo = '1;               hi = '1;               end
            4: begin lo = '0;               hi = '0;               end
            default: begin
               lo = DUTY_W'($urandom_range(20000, 0));
               hi = DUTY_W'($urandom_range(65535, 32'(lo)));
            end
         endcase
         write_csr(CSR_DUTY_MIN, lo);
         write_csr(CSR_DUTY_MAX, hi);
         @(posedge clock);
         flow_mode = flow_mode_type'(phase % 4);
         for (int i = 0; i < PHASE_ITEMS; i++)
            queue_reading(random_reading());
         wait_drained();
      end

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
